// ----- rtl/iopwm_pkg.sv -----
package iopwm_pkg;

	localparam logic [15:0] WindowReset = 16'd1000;

	// one quotient bit per step; only the low word of the quotient is ever kept
	localparam int DivSteps = 32;
	localparam int DivCntW  = $clog2(DivSteps);

	typedef struct packed {
		logic        is_read_cmd;
		logic [31:0] byte_count;
		logic [31:0] latency;
	} in_word_t;

	typedef struct packed {
		logic [15:0] read_rate;
		logic [15:0] write_rate;
		logic [15:0] total_rate;
		logic [47:0] read_bandwidth;
		logic [47:0] write_bandwidth;
		logic [47:0] total_bandwidth;
		logic [31:0] min_lat;
		logic [31:0] max_lat;
		logic [31:0] avg_lat;
		logic        window_published;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic upd;
		logic div_load;
		logic div_step;
		logic out_load;
	} cmd_t;

endpackage

// ----- rtl/iopwm_ctrl.sv -----
module iopwm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output iopwm_pkg::cmd_t cmd
);

	iopwm_pkg::state_t                 state_q, state_nxt;
	logic [iopwm_pkg::DivCntW-1:0]     cnt_q;
	logic                              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iopwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			iopwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.upd   = 1'b1;
					state_nxt = iopwm_pkg::ST_LOAD;
				end
			end
			iopwm_pkg::ST_LOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = iopwm_pkg::ST_DIV;
			end
			iopwm_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == iopwm_pkg::DivCntW'(iopwm_pkg::DivSteps - 1)) begin
					state_nxt = iopwm_pkg::ST_DONE;
				end
			end
			iopwm_pkg::ST_DONE: begin
				// wait here until the output word has been taken
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = iopwm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = iopwm_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/iopwm_dp.sv -----
module iopwm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  iopwm_pkg::cmd_t      cmd,
	input  iopwm_pkg::in_word_t  in_word,
	output iopwm_pkg::out_word_t out_word
);

	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (a == '1) ? a : a + 16'd1;
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

	logic [15:0] window_q;
	logic [15:0] items_q;
	logic [15:0] win_rd_cmds_q, win_wr_cmds_q;
	logic [47:0] win_rd_bytes_q, win_wr_bytes_q;
	logic [15:0] pub_rd_cmds_q, pub_wr_cmds_q;
	logic [47:0] pub_rd_bytes_q, pub_wr_bytes_q;
	logic [31:0] lat_min_q, lat_max_q;
	logic [63:0] lat_total_q;
	logic [31:0] lat_samples_q;
	logic        published_q;

	// divider
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic        quo_sat_q;
	logic [32:0] trial;
	logic        trial_ge;
	logic [32:0] trial_diff;

	iopwm_pkg::out_word_t out_q;

	logic        pub_hit;
	logic [15:0] items_base, rd_cmds_base, wr_cmds_base;
	logic [47:0] rd_bytes_base, wr_bytes_base;
	logic [64:0] lat_sum;
	logic [16:0] rate_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= iopwm_pkg::WindowReset;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	assign pub_hit       = items_q >= window_q;
	assign items_base    = pub_hit ? '0 : items_q;
	assign rd_cmds_base  = pub_hit ? '0 : win_rd_cmds_q;
	assign wr_cmds_base  = pub_hit ? '0 : win_wr_cmds_q;
	assign rd_bytes_base = pub_hit ? '0 : win_rd_bytes_q;
	assign wr_bytes_base = pub_hit ? '0 : win_wr_bytes_q;
	assign lat_sum       = {1'b0, lat_total_q} + {33'd0, in_word.latency};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_q        <= '0;
			win_rd_cmds_q  <= '0;
			win_wr_cmds_q  <= '0;
			win_rd_bytes_q <= '0;
			win_wr_bytes_q <= '0;
			pub_rd_cmds_q  <= '0;
			pub_wr_cmds_q  <= '0;
			pub_rd_bytes_q <= '0;
			pub_wr_bytes_q <= '0;
			lat_min_q      <= '0;
			lat_max_q      <= '0;
			lat_total_q    <= '0;
			lat_samples_q  <= '0;
			published_q    <= 1'b0;
		end else if (cmd.upd) begin
			if (pub_hit) begin
				pub_rd_cmds_q  <= win_rd_cmds_q;
				pub_wr_cmds_q  <= win_wr_cmds_q;
				pub_rd_bytes_q <= win_rd_bytes_q;
				pub_wr_bytes_q <= win_wr_bytes_q;
			end
			published_q <= pub_hit;
			items_q     <= sat_inc16(items_base);
			if (in_word.is_read_cmd) begin
				win_rd_cmds_q  <= sat_inc16(rd_cmds_base);
				win_rd_bytes_q <= sat_add48(rd_bytes_base, {16'd0, in_word.byte_count});
				win_wr_cmds_q  <= wr_cmds_base;
				win_wr_bytes_q <= wr_bytes_base;
			end else begin
				win_rd_cmds_q  <= rd_cmds_base;
				win_rd_bytes_q <= rd_bytes_base;
				win_wr_cmds_q  <= sat_inc16(wr_cmds_base);
				win_wr_bytes_q <= sat_add48(wr_bytes_base, {16'd0, in_word.byte_count});
			end
			// first sample seeds both extremes
			if (lat_samples_q == '0 || in_word.latency < lat_min_q) begin
				lat_min_q <= in_word.latency;
			end
			if (lat_samples_q == '0 || in_word.latency > lat_max_q) begin
				lat_max_q <= in_word.latency;
			end
			lat_total_q   <= lat_sum[64] ? '1 : lat_sum[63:0];
			lat_samples_q <= (lat_samples_q == '1) ? lat_samples_q : lat_samples_q + 32'd1;
		end
	end

	// Restoring divide of the low quotient word. High word nonzero means
	// the average does not fit and is forced to all ones.
	assign trial      = {rem_q, dvd_q[31]};
	assign trial_diff = trial - {1'b0, dvs_q};
	assign trial_ge   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q     <= lat_total_q[63:32];
			dvd_q     <= lat_total_q[31:0];
			dvs_q     <= lat_samples_q;
			quo_sat_q <= lat_total_q[63:32] >= lat_samples_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[30:0], trial_ge};
		end
	end

	assign rate_sum = {1'b0, pub_rd_cmds_q} + {1'b0, pub_wr_cmds_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.read_rate        <= pub_rd_cmds_q;
			out_q.write_rate       <= pub_wr_cmds_q;
			out_q.total_rate       <= rate_sum[16] ? '1 : rate_sum[15:0];
			out_q.read_bandwidth   <= pub_rd_bytes_q;
			out_q.write_bandwidth  <= pub_wr_bytes_q;
			out_q.total_bandwidth  <= sat_add48(pub_rd_bytes_q, pub_wr_bytes_q);
			out_q.min_lat          <= lat_min_q;
			out_q.max_lat          <= lat_max_q;
			out_q.avg_lat          <= quo_sat_q ? '1 : dvd_q;
			out_q.window_published <= published_q;
		end
	end

	assign out_word = out_q;

endmodule

// ----- rtl/io_performance_window_monitor.sv -----
// Windowed command-rate, bandwidth and latency monitor. Each input word is one
// completed command (read/write, bytes, latency in us); each produces exactly one
// output word holding the counts of the last published window, latency min/max
// since reset and the truncated average latency. A window closes when an item
// arrives and window_items items are already counted; that item publishes the
// window and starts the next. Each item passes through an update step, a divider
// load step, a one-bit-per-cycle restoring divider for the average, and an output
// register load that waits until the previous output word has been taken.
// in_ready is high only while no item is in flight; a finished word waits in the
// output register, and the next item may already be accepted while it waits.
// cfg_we writes window_items (reset 1000) and must only be used while idle.
module io_performance_window_monitor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  iopwm_pkg::in_word_t  in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output iopwm_pkg::out_word_t out_word
);

	iopwm_pkg::cmd_t cmd;

	iopwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	iopwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.in_word   (in_word),
		.out_word  (out_word)
	);

endmodule
